// ===== rtl/core/ansi_sgr_escape_parser_macros.svh =====
// assertion macros shared by the sgr parser rtl
// each macro samples on clk and is disabled while rst is high
`ifndef ANSI_SGR_ESCAPE_PARSER_MACROS_SVH
`define ANSI_SGR_ESCAPE_PARSER_MACROS_SVH

// condition holds at every clock edge
`define ASGR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASGR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/asgr_pkg.sv =====
// types, constants and the sgr code decoder for the sgr escape parser
// no dependencies
package asgr_pkg;

  localparam int ATTR_W = 10;

  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RESET = 10'd7;

  // configuration register addresses
  localparam logic [2:0] REG_DEFAULT_ATTR = 3'd0;

  // result kinds carried on tuser
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_ATTR = 1'b1;

  // special characters
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_CSI   = 8'h5B;
  localparam logic [7:0] CH_FINAL = 8'h6D;
  localparam logic [7:0] CH_SEP   = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // sgr codes
  localparam logic [7:0] SGR_RESET     = 8'd0;
  localparam logic [7:0] SGR_UL_ON     = 8'd4;
  localparam logic [7:0] SGR_UL_OFF    = 8'd24;
  localparam logic [7:0] SGR_REV_ON    = 8'd7;
  localparam logic [7:0] SGR_REV_OFF   = 8'd27;
  localparam logic [7:0] SGR_FG_BASE   = 8'd30;
  localparam logic [7:0] SGR_FG_LAST   = 8'd37;
  localparam logic [7:0] SGR_FGB_BASE  = 8'd90;
  localparam logic [7:0] SGR_FGB_LAST  = 8'd97;
  localparam logic [7:0] SGR_BG_BASE   = 8'd40;
  localparam logic [7:0] SGR_BG_LAST   = 8'd47;
  localparam logic [7:0] SGR_BGB_BASE  = 8'd100;
  localparam logic [7:0] SGR_BGB_LAST  = 8'd107;

  localparam logic [7:0] PARAM_MAX = 8'd255;

  // attribute bit positions
  localparam int FG_BRIGHT_BIT = 3;
  localparam int BG_BRIGHT_BIT = 7;
  localparam int UL_BIT        = 8;
  localparam int REV_BIT       = 9;

  typedef enum logic [1:0] {
    PH_TEXT,
    PH_ESC,
    PH_CSI
  } phase_t;

  typedef enum logic [2:0] {
    OP_TEXT,
    OP_OPEN,
    OP_DIGIT,
    OP_SEP,
    OP_COMMIT
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  data;
  } op_t;

  localparam int OP_W = $bits(op_t);

  // ansi colour index (bit0 red) to attribute colour bits (bit0 blue)
  function automatic logic [2:0] colour_map(input logic [2:0] n);
    colour_map = {n[0], n[1], n[2]};
  endfunction

  function automatic logic [ATTR_W-1:0] apply_code(input logic [ATTR_W-1:0] a,
                                                   input logic [7:0] code,
                                                   input logic [ATTR_W-1:0] dflt);
    logic [ATTR_W-1:0] r;
    logic [7:0]        off;
    r   = a;
    off = 8'd0;
    if (code == SGR_RESET) begin
      r = dflt;
    end else if (code == SGR_UL_ON) begin
      r[UL_BIT] = 1'b1;
    end else if (code == SGR_UL_OFF) begin
      r[UL_BIT] = 1'b0;
    end else if (code == SGR_REV_ON) begin
      r[REV_BIT] = 1'b1;
    end else if (code == SGR_REV_OFF) begin
      r[REV_BIT] = 1'b0;
    end else if (code inside {[SGR_FG_BASE:SGR_FG_LAST]}) begin
      off = code - SGR_FG_BASE;
      r[2:0] = colour_map(off[2:0]);
    end else if (code inside {[SGR_FGB_BASE:SGR_FGB_LAST]}) begin
      off = code - SGR_FGB_BASE;
      r[2:0] = colour_map(off[2:0]);
      r[FG_BRIGHT_BIT] = 1'b1;
    end else if (code inside {[SGR_BG_BASE:SGR_BG_LAST]}) begin
      off = code - SGR_BG_BASE;
      r[6:4] = colour_map(off[2:0]);
    end else if (code inside {[SGR_BGB_BASE:SGR_BGB_LAST]}) begin
      off = code - SGR_BGB_BASE;
      r[6:4] = colour_map(off[2:0]);
      r[BG_BRIGHT_BIT] = 1'b1;
    end
    apply_code = r;
  endfunction

endpackage

// ===== rtl/core/asgr_front.sv =====
// front end: accepts bytes, tracks the escape phase and turns bytes into ops
// depends on asgr_pkg
module asgr_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,     // [7:0] in_byte
  input  logic         q_full,
  output logic         push,
  output asgr_pkg::op_t push_op
);
  import asgr_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic       accept;
  logic       is_digit;
  logic       has_op;
  op_kind_t   kind;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);

  always_comb begin
    phase_next = phase;
    if (accept) begin
      case (phase)
        PH_CSI: begin
          if (!is_digit && s_tdata != CH_SEP) phase_next = PH_TEXT;
        end
        PH_ESC: begin
          if (s_tdata == CH_CSI)      phase_next = PH_CSI;
          else if (s_tdata == CH_ESC) phase_next = PH_ESC;
          else                        phase_next = PH_TEXT;
        end
        default: begin
          if (s_tdata == CH_ESC) phase_next = PH_ESC;
          else                   phase_next = PH_TEXT;
        end
      endcase
    end
  end

  // an escape byte or an aborted sequence produces no op
  always_comb begin
    has_op = 1'b0;
    kind   = OP_TEXT;
    case (phase)
      PH_CSI: begin
        has_op = 1'b1;
        if (is_digit)                  kind = OP_DIGIT;
        else if (s_tdata == CH_SEP)    kind = OP_SEP;
        else if (s_tdata == CH_FINAL)  kind = OP_COMMIT;
        else                           has_op = 1'b0;
      end
      PH_ESC: begin
        if (s_tdata == CH_CSI) begin
          has_op = 1'b1;
          kind   = OP_OPEN;
        end else begin
          has_op = (s_tdata != CH_ESC);
        end
      end
      default: begin
        has_op = (s_tdata != CH_ESC);
      end
    endcase
  end

  assign push         = accept && has_op;
  assign push_op.kind = kind;
  assign push_op.data = s_tdata;

  always_ff @(posedge clk) begin
    if (rst) phase <= PH_TEXT;
    else     phase <= phase_next;
  end

endmodule

// ===== rtl/core/asgr_queue.sv =====
// small flip-flop queue of ops between the front end and the back end
// depends on asgr_pkg
module asgr_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  asgr_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output asgr_pkg::op_t head_op
);
  import asgr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  op_t              entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_op    = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/core/asgr_back.sv =====
// back end: executes ops, holds the attribute state and the output register
// depends on asgr_pkg
module asgr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [asgr_pkg::ATTR_W-1:0] default_attr,
  input  logic                        head_valid,
  input  asgr_pkg::op_t               head_op,
  output logic                        pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [23:0]                 m_tdata,   // [7:0] text_byte, [17:8] attribute
  output logic                        m_tuser    // [0] result_kind
);
  import asgr_pkg::*;

  logic [7:0]        param;
  logic [7:0]        param_next;
  logic              has_digits;
  logic [ATTR_W-1:0] working;
  logic [ATTR_W-1:0] current;
  logic [ATTR_W-1:0] applied;
  logic [ATTR_W-1:0] committed;
  logic [11:0]       digit_sum;
  logic              emits;
  logic              out_kind;
  logic [7:0]        out_byte;
  logic [ATTR_W-1:0] out_attr;

  assign emits = (head_op.kind == OP_TEXT) || (head_op.kind == OP_COMMIT);
  // output register frees up when it is empty or its transaction completes
  assign pop   = head_valid && (!emits || !m_tvalid || m_tready);

  // param * 10 + digit
  assign digit_sum  = {1'b0, param, 3'b000} + {3'b000, param, 1'b0}
                    + {8'd0, head_op.data[3:0]};
  assign param_next = (digit_sum > {4'd0, PARAM_MAX}) ? PARAM_MAX : digit_sum[7:0];
  assign applied    = apply_code(working, param, default_attr);
  assign committed  = has_digits ? applied : working;

  always_ff @(posedge clk) begin
    if (rst) begin
      param      <= '0;
      has_digits <= 1'b0;
      working    <= DEFAULT_ATTR_RESET;
      current    <= DEFAULT_ATTR_RESET;
    end else if (pop) begin
      case (head_op.kind)
        OP_OPEN: begin
          param      <= '0;
          has_digits <= 1'b0;
          working    <= current;
        end
        OP_DIGIT: begin
          param      <= param_next;
          has_digits <= 1'b1;
        end
        OP_SEP: begin
          working    <= applied;
          param      <= '0;
          has_digits <= 1'b0;
        end
        OP_COMMIT: begin
          working    <= committed;
          current    <= committed;
          param      <= '0;
          has_digits <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && emits) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emits) begin
      if (head_op.kind == OP_COMMIT) begin
        out_kind <= KIND_ATTR;
        out_byte <= 8'd0;
        out_attr <= committed;
      end else begin
        out_kind <= KIND_TEXT;
        out_byte <= head_op.data;
        out_attr <= current;
      end
    end
  end

  assign m_tdata = {6'd0, out_attr, out_byte};
  assign m_tuser = out_kind;

endmodule

// ===== rtl/core/ansi_sgr_escape_parser.sv =====
// sgr escape parser: one byte per cycle in while s_tready is high, text bytes or attribute updates out
// a byte that makes a result is registered in the op queue and then in the output register before it shows on m_tvalid
// throughput: 1 byte per cycle while s_tready is high, set by the back end op loop
// the op queue (QUEUE_DEPTH entries) lets input run on while the output stalls
// reset: rst synchronous, clears phase, queue, output; attributes and default go to 7
// depends on asgr_pkg, asgr_front, asgr_queue, asgr_back
`include "ansi_sgr_escape_parser_macros.svh"

module ansi_sgr_escape_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [7:0] text_byte, [17:8] attribute
  output logic        m_tuser,    // [0] result_kind
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import asgr_pkg::*;

  logic [ATTR_W-1:0] default_attr;
  logic              cfg_wr;
  logic              q_full;
  logic              push;
  op_t               push_op;
  logic              pop;
  logic              head_valid;
  op_t               head_op;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == REG_DEFAULT_ATTR) ? {22'd0, default_attr} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= DEFAULT_ATTR_RESET;
    end else if (cfg_wr && paddr == REG_DEFAULT_ATTR) begin
      default_attr <= pwdata[ATTR_W-1:0];
    end
  end

  asgr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .push_op  (push_op)
  );

  asgr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  asgr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .default_attr (default_attr),
    .head_valid   (head_valid),
    .head_op      (head_op),
    .pop          (pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser)
  );

  `ASGR_ASSERT_IMPL(a_full_blocks_input, q_full, !s_tready, "input taken while op queue full")
  `ASGR_ASSERT_IMPL(a_attr_has_no_text, m_tvalid && m_tuser == KIND_ATTR, m_tdata[7:0] == 8'd0, "attribute update carries a text byte")
  `ASGR_ASSERT_NEXT(a_cfg_write_lands, cfg_wr && paddr == REG_DEFAULT_ATTR, default_attr == $past(pwdata[ATTR_W-1:0]), "default attribute write lost")
  `ASGR_ASSERT_ALWAYS(a_pop_needs_entry, !pop || head_valid, "op popped from empty queue")

endmodule
